FILE: sv/flsq_pkg.sv
package flsq_pkg;

  // sizing defaults for the top level parameters
  localparam int SLOTS_DEF     = 5;
  localparam int DIST_BITS_DEF = 12;

  // fixed field widths
  localparam int FEED_W  = 20;
  localparam int STAT_W  = 12;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int SPM_W   = 10;
  localparam int BOW_W   = 10;
  localparam int GEAR_W  = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register reset values
  localparam logic [SPM_W-1:0]  STEPS_RST  = 10'd144;
  localparam logic [BOW_W-1:0]  BOWDEN_RST = 10'd350;
  localparam logic [GEAR_W-1:0] GEAR_RST   = 8'd32;
  localparam logic              STOP_RST   = 1'b0;

  // statistics table reset for the minimum entries
  localparam logic [9:0] MIN_RESET = 10'd1000;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_STEPS  = 2'd0;
  localparam logic [1:0] REG_BOWDEN = 2'd1;
  localparam logic [1:0] REG_GEAR   = 2'd2;
  localparam logic [1:0] REG_STOP   = 2'd3;

  // opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // load phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SENSOR = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_BOWDEN = 3'd3;
  localparam logic [2:0] PH_SEEK   = 3'd4;
  localparam logic [2:0] PH_FINAL  = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SWITCH = 2'd1;
  localparam logic [1:0] ERR_SLOT   = 2'd2;

  // configuration register set
  typedef struct packed {
    logic [SPM_W-1:0]  steps_per_mm;
    logic [BOW_W-1:0]  bowden_mm;
    logic [GEAR_W-1:0] gear_mm;
    logic              sensor_stop_level;
  } cfg_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/flsq_regs.sv
module flsq_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [flsq_pkg::ADDR_W-1:0] paddr,
  input  logic [flsq_pkg::DATA_W-1:0] pwdata,
  output logic [flsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output flsq_pkg::cfg_t              cfg
);

  flsq_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps_per_mm      <= flsq_pkg::STEPS_RST;
      cfg_r.bowden_mm         <= flsq_pkg::BOWDEN_RST;
      cfg_r.gear_mm           <= flsq_pkg::GEAR_RST;
      cfg_r.sensor_stop_level <= flsq_pkg::STOP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        flsq_pkg::REG_STEPS:  cfg_r.steps_per_mm      <= pwdata[flsq_pkg::SPM_W-1:0];
        flsq_pkg::REG_BOWDEN: cfg_r.bowden_mm         <= pwdata[flsq_pkg::BOW_W-1:0];
        flsq_pkg::REG_GEAR:   cfg_r.gear_mm           <= pwdata[flsq_pkg::GEAR_W-1:0];
        flsq_pkg::REG_STOP:   cfg_r.sensor_stop_level <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      flsq_pkg::REG_STEPS:  prdata = flsq_pkg::DATA_W'(cfg_r.steps_per_mm);
      flsq_pkg::REG_BOWDEN: prdata = flsq_pkg::DATA_W'(cfg_r.bowden_mm);
      flsq_pkg::REG_GEAR:   prdata = flsq_pkg::DATA_W'(cfg_r.gear_mm);
      flsq_pkg::REG_STOP:   prdata = flsq_pkg::DATA_W'(cfg_r.sensor_stop_level);
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: sv/flsq_div.sv
module flsq_div (
  input  logic               clk,
  input  logic               rst_n,
  input  flsq_pkg::div_req_t req,
  output flsq_pkg::div_rsp_t rsp
);

  localparam int NW = flsq_pkg::SUM_W;
  localparam int DW = flsq_pkg::CNT_W;
  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign shifted = {rem_r, quo_r[NW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: sv/filament_load_sequencer_stats_top.sv
// result path: a transaction's result is held in the pending result register, then
//   moves to the output register; a report that records statistics first waits for the
//   32-step serial divider; no new transaction is taken before the output register loads
// reset: rst_n is synchronous, active low; phase idle, distance and tables cleared
//   (minimum entries to 1000), configuration back to its defaults
module filament_load_sequencer_stats_top #(
  parameter int SLOTS     = flsq_pkg::SLOTS_DEF,
  parameter int DIST_BITS = flsq_pkg::DIST_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [2:0]                   in_slot,
  input  logic [2:0]                   in_stats_slot,
  input  logic                         in_present_at_selector,
  input  logic                         in_head_switch_active,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [flsq_pkg::FEED_W-1:0]  out_feed_steps,
  output logic [2:0]                   out_phase,
  output logic                         out_done_res,
  output logic [1:0]                   out_error,
  output logic                         out_stat_valid,
  output logic [flsq_pkg::STAT_W-1:0]  out_stat_min,
  output logic [flsq_pkg::STAT_W-1:0]  out_stat_max,
  output logic [flsq_pkg::STAT_W-1:0]  out_stat_avg,
  output logic [flsq_pkg::CNT_W-1:0]   out_stat_count,
  // configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [flsq_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [flsq_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [flsq_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [3:0] SLOTS_V = 4'(SLOTS);
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam int SW = flsq_pkg::SUM_W;
  localparam int CW = flsq_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  flsq_pkg::cfg_t     cfg;
  flsq_pkg::div_req_t div_req;
  flsq_pkg::div_rsp_t div_rsp;

  state_t state_r, state_nxt;

  logic [2:0]           phase_r, phase_nxt;
  logic [DIST_BITS-1:0] distance_r, distance_nxt;
  logic [2:0]           sslot_r, sslot_nxt;

  logic [DIST_BITS-1:0] min_r [SLOTS];
  logic [DIST_BITS-1:0] max_r [SLOTS];
  logic [SW-1:0]        sum_r [SLOTS];
  logic [CW-1:0]        cnt_r [SLOTS];

  // pending result
  logic [flsq_pkg::FEED_W-1:0] res_feed_r;
  logic [2:0]                  res_phase_r;
  logic                        res_done_r;
  logic [1:0]                  res_err_r;
  logic                        res_sv_r;
  logic [flsq_pkg::STAT_W-1:0] res_min_r;
  logic [flsq_pkg::STAT_W-1:0] res_max_r;
  logic [CW-1:0]               res_cnt_r;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [flsq_pkg::FEED_W-1:0] out_feed_r;
  logic [2:0]                  out_phase_r;
  logic                        out_done_r;
  logic [1:0]                  out_err_r;
  logic                        out_sv_r;
  logic [flsq_pkg::STAT_W-1:0] out_min_r;
  logic [flsq_pkg::STAT_W-1:0] out_max_r;
  logic [flsq_pkg::STAT_W-1:0] out_avg_r;
  logic [CW-1:0]               out_cnt_r;

  logic                 accept;
  logic                 out_load;
  logic                 upd;
  logic                 done_v;
  logic [1:0]           err_v;
  logic [flsq_pkg::BOW_W-1:0] mul_op;
  logic [flsq_pkg::FEED_W-1:0] feed_v;
  logic                 slot_ok;
  logic [SLOT_IW-1:0]   sidx;
  logic [DIST_BITS-1:0] dist_seek;
  logic [DIST_BITS-1:0] cur_min, cur_max, new_min, new_max;
  logic [SW:0]          sum_ext;
  logic [SW-1:0]        new_sum;
  logic [CW-1:0]        cur_cnt, new_cnt;

  flsq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  flsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // statistics entry of the latched slot
  assign slot_ok   = ({1'b0, sslot_r} < SLOTS_V);
  assign sidx      = sslot_r[SLOT_IW-1:0];
  assign cur_min   = min_r[sidx];
  assign cur_max   = max_r[sidx];
  assign cur_cnt   = cnt_r[sidx];
  assign new_min   = (distance_r < cur_min) ? distance_r : cur_min;
  assign new_max   = (distance_r > cur_max) ? distance_r : cur_max;
  assign sum_ext   = {1'b0, sum_r[sidx]} + (SW + 1)'(distance_r);
  assign new_sum   = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
  assign new_cnt   = (cur_cnt != '1) ? cur_cnt + CW'(1) : cur_cnt;
  assign dist_seek = (distance_r != DIST_MAX) ? distance_r + DIST_BITS'(1) : distance_r;

  // sequencer decision for one transaction; feed is steps_per_mm times mul_op
  always_comb begin
    phase_nxt    = phase_r;
    distance_nxt = distance_r;
    sslot_nxt    = sslot_r;
    mul_op       = '0;
    done_v       = 1'b0;
    err_v        = flsq_pkg::ERR_NONE;
    upd          = 1'b0;
    if (in_opcode == flsq_pkg::OP_START) begin
      sslot_nxt    = in_stats_slot;
      distance_nxt = '0;
      phase_nxt    = flsq_pkg::PH_SENSOR;
      mul_op       = flsq_pkg::BOW_W'(1);
    end else begin
      case (phase_r)
        flsq_pkg::PH_SENSOR: begin
          if (in_present_at_selector != cfg.sensor_stop_level) begin
            mul_op = flsq_pkg::BOW_W'(1);
          end else if (in_head_switch_active) begin
            err_v     = flsq_pkg::ERR_SWITCH;
            phase_nxt = flsq_pkg::PH_WAIT;
          end else begin
            mul_op       = cfg.bowden_mm;
            distance_nxt = DIST_BITS'(cfg.bowden_mm);
            phase_nxt    = flsq_pkg::PH_BOWDEN;
          end
        end
        flsq_pkg::PH_WAIT: begin
          if (in_head_switch_active) begin
            err_v = flsq_pkg::ERR_SWITCH;
          end else begin
            mul_op       = cfg.bowden_mm;
            distance_nxt = DIST_BITS'(cfg.bowden_mm);
            phase_nxt    = flsq_pkg::PH_BOWDEN;
          end
        end
        flsq_pkg::PH_BOWDEN: begin
          distance_nxt = dist_seek;
          mul_op       = flsq_pkg::BOW_W'(1);
          phase_nxt    = flsq_pkg::PH_SEEK;
        end
        flsq_pkg::PH_SEEK: begin
          if (!in_head_switch_active) begin
            distance_nxt = dist_seek;
            mul_op       = flsq_pkg::BOW_W'(1);
          end else begin
            if (slot_ok) begin
              upd = 1'b1;
            end else begin
              err_v = flsq_pkg::ERR_SLOT;
            end
            mul_op    = flsq_pkg::BOW_W'(cfg.gear_mm);
            phase_nxt = flsq_pkg::PH_FINAL;
          end
        end
        flsq_pkg::PH_FINAL: begin
          done_v    = 1'b1;
          phase_nxt = flsq_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = flsq_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // single multiplier for every feed length
  assign feed_v = flsq_pkg::FEED_W'(cfg.steps_per_mm) * flsq_pkg::FEED_W'(mul_op);

  // divider launch for the running average
  assign div_req.start    = accept & upd;
  assign div_req.dividend = new_sum;
  assign div_req.divisor  = new_cnt;

  // control state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = upd ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_load      = (state_r == ST_OUT) & (~out_valid_r | out_ready);
  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= flsq_pkg::PH_IDLE;
      distance_r  <= '0;
      sslot_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r    <= phase_nxt;
        distance_r <= distance_nxt;
        sslot_r    <= sslot_nxt;
      end
    end
  end

  // statistics tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        min_r[i] <= DIST_BITS'(flsq_pkg::MIN_RESET);
        max_r[i] <= '0;
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (accept && upd) begin
      min_r[sidx] <= new_min;
      max_r[sidx] <= new_max;
      sum_r[sidx] <= new_sum;
      cnt_r[sidx] <= new_cnt;
    end
  end

  // pending result captured at the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      res_feed_r  <= feed_v;
      res_phase_r <= phase_nxt;
      res_done_r  <= done_v;
      res_err_r   <= err_v;
      res_sv_r    <= upd;
      res_min_r   <= upd ? flsq_pkg::STAT_W'(new_min) : '0;
      res_max_r   <= upd ? flsq_pkg::STAT_W'(new_max) : '0;
      res_cnt_r   <= upd ? new_cnt : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_feed_r  <= res_feed_r;
      out_phase_r <= res_phase_r;
      out_done_r  <= res_done_r;
      out_err_r   <= res_err_r;
      out_sv_r    <= res_sv_r;
      out_min_r   <= res_min_r;
      out_max_r   <= res_max_r;
      out_avg_r   <= res_sv_r ? div_rsp.quotient[flsq_pkg::STAT_W-1:0] : '0;
      out_cnt_r   <= res_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_feed_steps = out_feed_r;
  assign out_phase      = out_phase_r;
  assign out_done_res   = out_done_r;
  assign out_error      = out_err_r;
  assign out_stat_valid = out_sv_r;
  assign out_stat_min   = out_min_r;
  assign out_stat_max   = out_max_r;
  assign out_stat_avg   = out_avg_r;
  assign out_stat_count = out_cnt_r;

endmodule

FILE: sv/flsq_chk.sv
module flsq_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [flsq_pkg::FEED_W-1:0] out_feed_steps,
  input logic [2:0]                  out_phase,
  input logic                        out_done_res,
  input logic [1:0]                  out_error,
  input logic                        out_stat_valid,
  input logic [flsq_pkg::STAT_W-1:0] out_stat_min,
  input logic [flsq_pkg::STAT_W-1:0] out_stat_max,
  input logic [flsq_pkg::STAT_W-1:0] out_stat_avg,
  input logic [flsq_pkg::CNT_W-1:0]  out_stat_count
);

  // one transaction at a time: the input closes right after a transaction
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_feed_steps) && $stable(out_phase)
      && $stable(out_stat_count))
    else $error("stalled result changed");

  // completion always returns to idle with no feed
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_phase == flsq_pkg::PH_IDLE && out_feed_steps == '0)
    else $error("done without idle phase");

  // statistics only come with the final feed and a clean status
  a_stat_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stat_valid |->
      out_phase == flsq_pkg::PH_FINAL && out_error == flsq_pkg::ERR_NONE
      && out_stat_count != '0)
    else $error("statistics outside the final feed");

  // stale statistics read as zero
  a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stat_valid |->
      out_stat_min == '0 && out_stat_max == '0 && out_stat_avg == '0
      && out_stat_count == '0)
    else $error("statistics fields not cleared");

endmodule

bind filament_load_sequencer_stats_top flsq_chk u_flsq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_feed_steps (out_feed_steps),
  .out_phase      (out_phase),
  .out_done_res   (out_done_res),
  .out_error      (out_error),
  .out_stat_valid (out_stat_valid),
  .out_stat_min   (out_stat_min),
  .out_stat_max   (out_stat_max),
  .out_stat_avg   (out_stat_avg),
  .out_stat_count (out_stat_count)
);
